// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bbsf_pkg.sv =====
// Package with the types and constants of the bounded byte stream FIFO.
package bbsf_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 11;
  localparam int TOT_W  = 64;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_CLOSE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic fetch;
  } cmd_t;

endpackage

// ===== src/bounded_byte_stream_fifo.sv =====
// Top level of the bounded byte stream FIFO.
// A request is taken at a rising edge of clk with start high and busy low.
// in_func selects push of in_data_byte, pop of in_pop_length bytes, or close
// of the writer side; code 3 only reports the current status.
// Every request returns one result, shown for exactly one cycle with
// out_valid high; the receiver cannot stall, so the result must be taken then.
// After the request is taken, the EXEC state updates pointers, counters and
// the byte store, the FETCH state reads the front byte from the registered
// store port, and the RESP state presents the result.
// busy is low during the result cycle, so a new request can be taken there;
// in the EXEC and FETCH states busy is high and no request is taken.
// cfg_wr_en writes cfg_wr_data into the capacity register; write it only
// while no request is in flight.
// A synchronous low rst_n empties the FIFO, clears the totals and the closed
// flag, and sets the capacity to 1024. The byte store is not cleared.
module bounded_byte_stream_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_data_byte,
  input  logic [bbsf_pkg::CNT_W-1:0]    in_pop_length,
  input  logic                          cfg_wr_en,
  input  logic [bbsf_pkg::CNT_W-1:0]    cfg_wr_data,
  output logic                          out_valid,
  output logic                          out_accepted,
  output logic [7:0]                    out_front_byte,
  output logic                          out_front_valid,
  output logic [bbsf_pkg::CNT_W-1:0]    out_bytes_held,
  output logic [bbsf_pkg::CNT_W-1:0]    out_free_space,
  output logic [bbsf_pkg::TOT_W-1:0]    out_total_pushed,
  output logic [bbsf_pkg::TOT_W-1:0]    out_total_popped,
  output logic                          out_closed_flag,
  output logic                          out_finished_flag
);

  bbsf_pkg::cmd_t cmd;

  bbsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bbsf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .in_pop_length     (in_pop_length),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_accepted      (out_accepted),
    .out_front_byte    (out_front_byte),
    .out_front_valid   (out_front_valid),
    .out_bytes_held    (out_bytes_held),
    .out_free_space    (out_free_space),
    .out_total_pushed  (out_total_pushed),
    .out_total_popped  (out_total_popped),
    .out_closed_flag   (out_closed_flag),
    .out_finished_flag (out_finished_flag)
  );

endmodule

// ===== src/bbsf_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
module bbsf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  output bbsf_pkg::cmd_t   cmd
);

  bbsf_pkg::state_t state_r;
  bbsf_pkg::state_t state_nxt;
  logic             take;

  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbsf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbsf_pkg::ST_IDLE: begin
        if (take) state_nxt = bbsf_pkg::ST_EXEC;
      end
      bbsf_pkg::ST_EXEC:  state_nxt = bbsf_pkg::ST_FETCH;
      bbsf_pkg::ST_FETCH: state_nxt = bbsf_pkg::ST_RESP;
      bbsf_pkg::ST_RESP: begin
        state_nxt = take ? bbsf_pkg::ST_EXEC : bbsf_pkg::ST_IDLE;
      end
      default: state_nxt = bbsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      bbsf_pkg::ST_IDLE:  busy = 1'b0;
      bbsf_pkg::ST_EXEC:  busy = 1'b1;
      bbsf_pkg::ST_FETCH: busy = 1'b1;
      bbsf_pkg::ST_RESP:  out_valid = 1'b1;
      default:            busy = 1'b0;
    endcase
    cmd.latch = take;
    cmd.exec  = (state_r == bbsf_pkg::ST_EXEC);
    cmd.fetch = (state_r == bbsf_pkg::ST_FETCH);
  end

endmodule

// ===== src/bbsf_datapath.sv =====
// Datapath with the byte store, pointers, counters and result fields.
module bbsf_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbsf_pkg::cmd_t                cmd,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_data_byte,
  input  logic [bbsf_pkg::CNT_W-1:0]    in_pop_length,
  input  logic                          cfg_wr_en,
  input  logic [bbsf_pkg::CNT_W-1:0]    cfg_wr_data,
  output logic                          out_accepted,
  output logic [7:0]                    out_front_byte,
  output logic                          out_front_valid,
  output logic [bbsf_pkg::CNT_W-1:0]    out_bytes_held,
  output logic [bbsf_pkg::CNT_W-1:0]    out_free_space,
  output logic [bbsf_pkg::TOT_W-1:0]    out_total_pushed,
  output logic [bbsf_pkg::TOT_W-1:0]    out_total_popped,
  output logic                          out_closed_flag,
  output logic                          out_finished_flag
);

  localparam int AW = bbsf_pkg::ADDR_W;
  localparam int CW = bbsf_pkg::CNT_W;
  localparam int TW = bbsf_pkg::TOT_W;

  logic [7:0]    mem [bbsf_pkg::DEPTH];

  logic [1:0]    func_r;
  logic [7:0]    data_r;
  logic [CW-1:0] len_r;
  logic [CW-1:0] cap_r;
  logic [AW-1:0] rd_pos_r;
  logic [AW-1:0] wr_pos_r;
  logic [CW-1:0] held_r;
  logic [TW-1:0] pushed_r;
  logic [TW-1:0] popped_r;
  logic          closed_r;
  logic          acc_r;
  logic [7:0]    rd_data_r;

  logic [CW-1:0] cap_eff;
  logic [CW-1:0] free_cnt;
  logic          push_ok;
  logic          is_pop;
  logic [CW-1:0] pop_n;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                            input logic [CW-1:0] n);
    logic [CW:0] sum;
    sum = (CW+1)'(pos) + (CW+1)'(n);
    if (sum >= (CW+1)'(bbsf_pkg::DEPTH)) begin
      sum = sum - (CW+1)'(bbsf_pkg::DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    cap_eff  = (cap_r > CW'(bbsf_pkg::DEPTH)) ? CW'(bbsf_pkg::DEPTH) : cap_r;
    free_cnt = (held_r < cap_eff) ? (cap_eff - held_r) : '0;
    push_ok  = (func_r == bbsf_pkg::FN_PUSH) && !closed_r && (free_cnt != '0);
    is_pop   = (func_r == bbsf_pkg::FN_POP);
    pop_n    = (len_r > held_r) ? held_r : len_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      data_r <= in_data_byte;
      len_r  <= in_pop_length;
    end
    if (cmd.exec) begin
      acc_r <= push_ok;
      if (push_ok) mem[wr_pos_r] <= data_r;
    end
    if (cmd.fetch) begin
      rd_data_r <= mem[rd_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= bbsf_pkg::CAP_RESET;
      rd_pos_r <= '0;
      wr_pos_r <= '0;
      held_r   <= '0;
      pushed_r <= '0;
      popped_r <= '0;
      closed_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (cmd.exec) begin
        if (push_ok) begin
          wr_pos_r <= advance(wr_pos_r, CW'(1));
          held_r   <= held_r + CW'(1);
          pushed_r <= pushed_r + TW'(1);
        end else if (is_pop) begin
          rd_pos_r <= advance(rd_pos_r, pop_n);
          held_r   <= held_r - pop_n;
          popped_r <= popped_r + TW'(pop_n);
        end else if (func_r == bbsf_pkg::FN_CLOSE) begin
          closed_r <= 1'b1;
        end
      end
    end
  end

  assign out_accepted      = acc_r;
  assign out_front_valid   = (held_r != '0);
  assign out_front_byte    = out_front_valid ? rd_data_r : 8'd0;
  assign out_bytes_held    = held_r;
  assign out_free_space    = free_cnt;
  assign out_total_pushed  = pushed_r;
  assign out_total_popped  = popped_r;
  assign out_closed_flag   = closed_r;
  assign out_finished_flag = closed_r && (held_r == '0);

endmodule

// ===== src/bbsf_checker.sv =====
// Port-level checker for the bounded byte stream FIFO and its bind.
`include "assert_macros.svh"

module bbsf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_front_valid,
  input logic [bbsf_pkg::CNT_W-1:0]    out_bytes_held,
  input logic                          out_closed_flag,
  input logic                          out_finished_flag
);

  logic take;
  logic held_nz;
  logic fin_seen;

  assign take     = start && !busy;
  assign held_nz  = (out_bytes_held != '0);
  assign fin_seen = out_valid && out_finished_flag;

  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")
  `ASSERT_CLK(a_take_busy, take |=> busy, "request taken but busy stayed low")
  `ASSERT_CLK(a_latency, take |-> ##3 out_valid, "result not three cycles after request")
  `ASSERT_CLK(a_front_valid, out_valid |-> (out_front_valid == held_nz), "bad front valid")
  `ASSERT_CLK(a_finished, fin_seen |-> (out_closed_flag && !out_front_valid), "bad finished")

endmodule

bind bounded_byte_stream_fifo bbsf_checker u_bbsf_checker (.*);

// ===== bench/bbsf_status_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the FIFO status after each request and compares every result.
module bbsf_status_checker
  import bbsf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_data_byte,
  input  logic [CNT_W-1:0] in_pop_length,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             out_valid,
  input  logic             out_accepted,
  input  logic [7:0]       out_front_byte,
  input  logic             out_front_valid,
  input  logic [CNT_W-1:0] out_bytes_held,
  input  logic [CNT_W-1:0] out_free_space,
  input  logic [TOT_W-1:0] out_total_pushed,
  input  logic [TOT_W-1:0] out_total_popped,
  input  logic             out_closed_flag,
  input  logic             out_finished_flag,
  output int               failures,
  output int               pending,
  output int               results_checked
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic             accepted;
    logic [7:0]       front_byte;
    logic             front_valid;
    logic [CNT_W-1:0] bytes_held;
    logic [CNT_W-1:0] free_space;
    logic [TOT_W-1:0] total_pushed;
    logic [TOT_W-1:0] total_popped;
    logic             closed_flag;
    logic             finished_flag;
  } fifo_status_t;

  logic [7:0]       shadow_store [DEPTH];
  int               rd_pos;
  int               wr_pos;
  int               held;
  logic [TOT_W-1:0] pushed_sum;
  logic [TOT_W-1:0] popped_sum;
  logic             writer_closed;
  logic [CNT_W-1:0] capacity;
  fifo_status_t     status_q [$];
  fifo_status_t     want;
  int               mismatches = 0;
  int               checked = 0;

  assign failures        = mismatches;
  assign results_checked = checked;

  initial pending = 0;

  function automatic int space_left();
    int cap;
    cap = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    return (held >= cap) ? 0 : cap - held;
  endfunction

  function automatic fifo_status_t apply_request(logic [1:0] fn, logic [7:0] data,
                                                 logic [CNT_W-1:0] len);
    fifo_status_t s;
    int n;
    s.accepted = 1'b0;
    case (fn)
      FN_PUSH: begin
        if (!writer_closed && space_left() > 0) begin
          shadow_store[wr_pos] = data;
          wr_pos = (wr_pos + 1) % DEPTH;
          held++;
          pushed_sum++;
          s.accepted = 1'b1;
        end
      end
      FN_POP: begin
        n = (int'(len) > held) ? held : int'(len);
        rd_pos = (rd_pos + n) % DEPTH;
        held -= n;
        popped_sum += TOT_W'(n);
      end
      FN_CLOSE: begin
        writer_closed = 1'b1;
      end
      default: ;
    endcase
    s.front_valid   = (held > 0);
    s.front_byte    = (held > 0) ? shadow_store[rd_pos] : 8'h00;
    s.bytes_held    = CNT_W'(held);
    s.free_space    = CNT_W'(space_left());
    s.total_pushed  = pushed_sum;
    s.total_popped  = popped_sum;
    s.closed_flag   = writer_closed;
    s.finished_flag = writer_closed && (held == 0);
    return s;
  endfunction

  task automatic check_field(string field, logic [TOT_W-1:0] exp_val,
                             logic [TOT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rd_pos        = 0;
      wr_pos        = 0;
      held          = 0;
      pushed_sum    = '0;
      popped_sum    = '0;
      writer_closed = 1'b0;
      capacity      = CAP_RESET;
      status_q.delete();
    end else begin
      if (cfg_wr_en)
        capacity = cfg_wr_data;
      if (out_valid) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result arrived with no request outstanding", $time);
        end else begin
          want = status_q.pop_front();
          checked++;
          check_field("accepted", TOT_W'(want.accepted), TOT_W'(out_accepted));
          check_field("front_byte", TOT_W'(want.front_byte), TOT_W'(out_front_byte));
          check_field("front_valid", TOT_W'(want.front_valid), TOT_W'(out_front_valid));
          check_field("bytes_held", TOT_W'(want.bytes_held), TOT_W'(out_bytes_held));
          check_field("free_space", TOT_W'(want.free_space), TOT_W'(out_free_space));
          check_field("total_pushed", want.total_pushed, out_total_pushed);
          check_field("total_popped", want.total_popped, out_total_popped);
          check_field("closed_flag", TOT_W'(want.closed_flag), TOT_W'(out_closed_flag));
          check_field("finished_flag", TOT_W'(want.finished_flag),
                      TOT_W'(out_finished_flag));
        end
      end
      if (start && !busy)
        status_q.push_back(apply_request(in_func, in_data_byte, in_pop_length));
    end
    pending <= status_q.size();
  end

endmodule

// ===== bench/tb_bounded_byte_stream_fifo.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, request stimulus, capacity writes and the final verdict.
module tb_bounded_byte_stream_fifo;
  import bbsf_pkg::*;

  localparam logic [1:0] FN_STATUS = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 40;
  localparam int FILL_ITEMS     = 260;
  localparam int REFILL_ITEMS   = 100;
  localparam int CLOSE_ITEMS    = 40;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_func = FN_PUSH;
  logic [7:0]       in_data_byte = 8'h00;
  logic [CNT_W-1:0] in_pop_length = '0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             out_valid;
  logic             out_accepted;
  logic [7:0]       out_front_byte;
  logic             out_front_valid;
  logic [CNT_W-1:0] out_bytes_held;
  logic [CNT_W-1:0] out_free_space;
  logic [TOT_W-1:0] out_total_pushed;
  logic [TOT_W-1:0] out_total_popped;
  logic             out_closed_flag;
  logic             out_finished_flag;

  int failures;
  int pending;
  int results_checked;

  int idle_pct = 0;
  int idle_cycles = 0;
  int push_count = 0;
  int pop_count = 0;
  int close_count = 0;
  int status_count = 0;
  int cap_writes = 0;
  int idle_modes [4] = '{0, 65, 0, 24};
  logic [CNT_W-1:0] phase_caps [8] = '{11'd0, 11'd1, 11'd2, 11'd7, 11'd2047, 11'd16,
                                       11'd1024, 11'd3};

  bounded_byte_stream_fifo u_dut (.*);

  bbsf_status_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] fn, logic [7:0] data, logic [CNT_W-1:0] len);
    int gap;
    start         <= 1'b1;
    in_func       <= fn;
    in_data_byte  <= data;
    in_pop_length <= len;
    do @(posedge clk); while (busy);
    case (fn)
      FN_PUSH:  push_count++;
      FN_POP:   pop_count++;
      FN_CLOSE: close_count++;
      default:  status_count++;
    endcase
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) begin
        in_func       <= 2'($urandom);
        in_data_byte  <= 8'($urandom);
        in_pop_length <= CNT_W'($urandom);
        @(posedge clk);
      end
    end
  endtask

  task automatic random_request(int push_pct, bit allow_close);
    int roll;
    int pick;
    logic [CNT_W-1:0] len;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (pick < 6)
      len = CNT_W'($urandom_range(0, 4));
    else if (pick < 8)
      len = CNT_W'($urandom_range(0, DEPTH));
    else
      len = CNT_W'($urandom);
    if (roll < 4)
      send_request(FN_STATUS, 8'($urandom), len);
    else if (allow_close && roll < 10)
      send_request(FN_CLOSE, 8'($urandom), len);
    else if (roll < push_pct)
      send_request(FN_PUSH, 8'($urandom), len);
    else
      send_request(FN_POP, 8'($urandom), len);
  endtask

  // Drop start, let every outstanding result come back, then allow the pipeline to drain.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_writes++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(FN_STATUS, 8'h00, '0);
    send_request(FN_POP, 8'h00, '0);
    send_request(FN_POP, 8'h00, 11'h7FF);
    send_request(FN_PUSH, 8'h00, '0);
    send_request(FN_PUSH, 8'hFF, 11'h7FF);
    send_request(FN_PUSH, 8'hA5, '0);
    send_request(FN_PUSH, 8'h5A, '0);
    send_request(FN_STATUS, 8'hFF, 11'h7FF);
    send_request(FN_POP, 8'h00, 11'd1);
    send_request(FN_POP, 8'h00, 11'd0);
    send_request(FN_POP, 8'h00, 11'd1024);
    send_request(FN_PUSH, 8'h80, '0);
    send_request(FN_PUSH, 8'h01, '0);
    send_request(FN_POP, 8'h00, 11'd2);
    write_capacity(11'd0);
    send_request(FN_PUSH, 8'h3C, '0);
    send_request(FN_POP, 8'h00, 11'd1);
    write_capacity(11'd1);
    send_request(FN_PUSH, 8'h11, '0);
    send_request(FN_PUSH, 8'h22, '0);
    send_request(FN_POP, 8'h00, 11'd5);

    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      idle_pct = idle_modes[p % 4];
      repeat (PHASE_ITEMS) random_request(60, 1'b0);
    end

    // Fill deep into the store, then shrink the capacity under the fill.
    write_capacity(11'd2047);
    idle_pct = idle_modes[3];
    repeat (FILL_ITEMS) send_request(FN_PUSH, 8'($urandom), CNT_W'($urandom));
    send_request(FN_POP, 8'($urandom), 11'(REFILL_ITEMS));
    repeat (REFILL_ITEMS) send_request(FN_PUSH, 8'($urandom), CNT_W'($urandom));
    write_capacity(11'd4);
    idle_pct = idle_modes[1];
    send_request(FN_PUSH, 8'h77, '0);
    repeat (PHASE_ITEMS) random_request(40, 1'b0);

    write_capacity(11'd8);
    idle_pct = idle_modes[0];
    repeat (6) send_request(FN_PUSH, 8'($urandom), '0);
    send_request(FN_CLOSE, 8'h00, '0);
    send_request(FN_CLOSE, 8'hFF, 11'h7FF);
    send_request(FN_PUSH, 8'hE1, '0);
    send_request(FN_STATUS, 8'h00, '0);
    idle_pct = idle_modes[3];
    repeat (CLOSE_ITEMS) random_request(50, 1'b1);
    send_request(FN_POP, 8'h00, 11'h7FF);

    settle();
    $display("Run covered %0d requests: %0d push, %0d pop, %0d close, %0d status.",
             push_count + pop_count + close_count + status_count, push_count, pop_count,
             close_count, status_count);
    $display("%0d capacity writes from 0 to 2047, %0d results compared, %0d left waiting.",
             cap_writes, results_checked, pending);
    if (failures == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== bounded_byte_stream_fifo.f =====
+incdir+src
src/bbsf_pkg.sv
src/bbsf_ctrl.sv
src/bbsf_datapath.sv
src/bounded_byte_stream_fifo.sv
src/bbsf_checker.sv
bench/bbsf_status_checker.sv
bench/tb_bounded_byte_stream_fifo.sv
